// File: src/kclp_pkg.sv
// Shared types and constants for the k-mer count line parser.
package kclp_pkg;

   // character codes
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   // field widths
   localparam int PREFIX_CODE_W = 26;
   localparam int SUFFIX_CODE_W = 16;
   localparam int KMER_COUNT_W  = 16;
   localparam int SHARD_W       = 20;
   localparam int COUNT_ACC_W   = 17;
   localparam int SHARD_WIDTH_W = 5;
   localparam int MAX_REC_W     = 32;

   localparam logic [COUNT_ACC_W-1:0]   COUNT_SAT = 17'h10000;
   localparam logic [SHARD_WIDTH_W-1:0] SHARD_MIN = 5'd1;
   localparam logic [SHARD_WIDTH_W-1:0] SHARD_MAX = 5'd20;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHARD_WIDTH = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RECORDS = 1'b1;

   localparam logic [SHARD_WIDTH_W-1:0] SHARD_WIDTH_RESET = 5'd12;
   localparam logic [MAX_REC_W-1:0]     MAX_RECORDS_RESET = 32'd0;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic                     record_kept;
      logic [PREFIX_CODE_W-1:0] prefix_code;
      logic [SUFFIX_CODE_W-1:0] suffix_code;
      logic [KMER_COUNT_W-1:0]  kmer_count;
      logic                     count_clamped;
      logic [SHARD_W-1:0]       shard_index;
   } rsp_type;

   // classified byte handed from front to back
   typedef struct packed {
      logic       eoi;
      logic       is_ws;
      logic       is_lf;
      logic       is_base;
      logic [1:0] base_code;
      logic       is_digit;
      logic [3:0] digit;
   } class_type;

endpackage

// File: src/kclp_front.sv
// Front end: accepts text beats and classifies each byte.
module kclp_front
   import kclp_pkg::*;
(
   input  logic      req_valid,
   input  req_type   req_data,
   output logic      req_stall,
   input  logic      queue_full,
   output logic      push,
   output class_type push_item
);

   logic [7:0] c;

   assign c         = req_data.text_byte;
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_item          = '0;
      push_item.eoi      = req_data.end_of_input;
      push_item.is_lf    = (c == CHAR_LF);
      push_item.is_ws    = (c == CHAR_SPACE) || (c == CHAR_TAB) ||
                           (c == CHAR_LF) || (c == CHAR_CR);
      push_item.is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      push_item.digit    = c[3:0];
      case (c)
         "A", "a": begin
            push_item.is_base   = 1'b1;
            push_item.base_code = BASE_A;
         end
         "C", "c": begin
            push_item.is_base   = 1'b1;
            push_item.base_code = BASE_C;
         end
         "G", "g": begin
            push_item.is_base   = 1'b1;
            push_item.base_code = BASE_G;
         end
         "T", "t": begin
            push_item.is_base   = 1'b1;
            push_item.base_code = BASE_T;
         end
         default: begin
            push_item.is_base   = 1'b0;
            push_item.base_code = BASE_A;
         end
      endcase
   end

endmodule

// File: src/kclp_queue.sv
// Short queue of classified bytes between front and back.
module kclp_queue
   import kclp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  class_type push_item,
   output logic      full,
   input  logic      pop,
   output logic      pop_valid,
   output class_type pop_item
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   class_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/kclp_back.sv
// Back end: line parser state machine and result register.
module kclp_back
   import kclp_pkg::*;
#(
   parameter int PREFIX_BASES = 13,
   parameter int KMER_BASES   = 21
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  class_type                q_item,
   output logic                     q_pop,
   input  logic [SHARD_WIDTH_W-1:0] shard_width,
   input  logic [MAX_REC_W-1:0]     max_records,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data
);

   localparam int PW = 2 * PREFIX_BASES;
   localparam int PB = $clog2(KMER_BASES + 1);

   typedef enum logic [5:0] {
      PH_SKIP    = 6'b000001,
      PH_BASES   = 6'b000010,
      PH_AFTER   = 6'b000100,
      PH_GAP     = 6'b001000,
      PH_COUNT   = 6'b010000,
      PH_DISCARD = 6'b100000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [PB-1:0]          pos_ff, pos_in;
   logic [PW-1:0]          prefix_ff, prefix_in;
   logic [15:0]            suffix_ff, suffix_in;
   logic [COUNT_ACC_W-1:0] count_ff, count_in;
   logic                   saw_digit_ff, saw_digit_in;
   logic                   line_bad_ff, line_bad_in;
   logic [MAX_REC_W-1:0]   kept_ff, kept_in;
   logic                   stopped_ff, stopped_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                     line_start, do_base, finish, fin_bad, kept;
   logic [PB-1:0]            pos_src, pos_next;
   logic [31:0]              pre_src_ext, pre_shift, pre_ext, pre_shard;
   logic [15:0]              suf_src;
   logic [20:0]              count_mul;
   logic [SHARD_WIDTH_W-1:0] sb_c;
   logic [5:0]               sh;
   rsp_type                  res;

   assign q_pop     = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // shard index from the current prefix
   always_comb begin
      if (shard_width < SHARD_MIN) begin
         sb_c = SHARD_MIN;
      end else if (shard_width > SHARD_MAX) begin
         sb_c = SHARD_MAX;
      end else begin
         sb_c = shard_width;
      end
      if (6'(PW) > {1'b0, sb_c}) begin
         sh = 6'(PW) - {1'b0, sb_c};
      end else begin
         sh = '0;
      end
      pre_ext   = 32'(prefix_ff);
      pre_shard = pre_ext >> sh;
   end

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      prefix_in    = prefix_ff;
      suffix_in    = suffix_ff;
      count_in     = count_ff;
      saw_digit_in = saw_digit_ff;
      line_bad_in  = line_bad_ff;
      kept_in      = kept_ff;
      stopped_in   = stopped_ff;
      line_start   = 1'b0;
      do_base      = 1'b0;
      finish       = 1'b0;
      fin_bad      = line_bad_ff;
      count_mul    = (21'(count_ff) << 3) + (21'(count_ff) << 1) + 21'(q_item.digit);

      if (q_pop) begin
         if (stopped_ff || (phase_ff == PH_SKIP && max_records != '0 &&
                            kept_ff >= max_records)) begin
            stopped_in = 1'b1;
         end else if (q_item.eoi) begin
            case (phase_ff)
               PH_SKIP: ;
               PH_BASES, PH_AFTER, PH_GAP: begin
                  fin_bad = 1'b1;
                  finish  = 1'b1;
               end
               default: finish = 1'b1;
            endcase
         end else begin
            case (phase_ff)
               PH_SKIP: begin
                  if (!q_item.is_ws) begin
                     line_start   = 1'b1;
                     do_base      = 1'b1;
                     count_in     = '0;
                     saw_digit_in = 1'b0;
                     line_bad_in  = 1'b0;
                  end
               end
               PH_BASES: begin
                  if (q_item.is_lf) begin
                     fin_bad = 1'b1;
                     finish  = 1'b1;
                  end else begin
                     do_base = 1'b1;
                  end
               end
               PH_AFTER: begin
                  if (q_item.is_ws) begin
                     phase_in = PH_GAP;
                  end else begin
                     line_bad_in = 1'b1;
                     phase_in    = PH_DISCARD;
                  end
               end
               PH_GAP: begin
                  if (q_item.is_digit) begin
                     saw_digit_in = 1'b1;
                     count_in     = COUNT_ACC_W'(q_item.digit);
                     phase_in     = PH_COUNT;
                  end else if (!q_item.is_ws) begin
                     phase_in = PH_DISCARD;
                  end
               end
               PH_COUNT: begin
                  if (q_item.is_digit) begin
                     if (!count_ff[COUNT_ACC_W-1]) begin
                        if (count_mul > 21'(COUNT_SAT)) begin
                           count_in = COUNT_SAT;
                        end else begin
                           count_in = count_mul[COUNT_ACC_W-1:0];
                        end
                     end
                  end else if (q_item.is_lf) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = PH_DISCARD;
                  end
               end
               default: begin
                  if (q_item.is_lf) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = PH_DISCARD;
                  end
               end
            endcase
         end
      end

      // one base into the token; a new line starts from empty accumulators
      pos_src     = line_start ? '0 : pos_ff;
      pre_src_ext = line_start ? '0 : 32'(prefix_ff);
      suf_src     = line_start ? '0 : suffix_ff;
      pre_shift   = (pre_src_ext << 2) | 32'(q_item.base_code);
      pos_next    = pos_src + 1'b1;
      if (do_base) begin
         pos_in    = pos_src;
         prefix_in = pre_src_ext[PW-1:0];
         suffix_in = suf_src;
         if (!q_item.is_base) begin
            line_bad_in = 1'b1;
            phase_in    = PH_DISCARD;
         end else begin
            if (int'(pos_src) < PREFIX_BASES) begin
               prefix_in = pre_shift[PW-1:0];
            end else begin
               suffix_in = {suf_src[13:0], q_item.base_code};
            end
            pos_in   = pos_next;
            phase_in = (int'(pos_next) >= KMER_BASES) ? PH_AFTER : PH_BASES;
         end
      end

      kept = !fin_bad && saw_digit_ff;
      res  = '0;
      if (finish) begin
         phase_in    = PH_SKIP;
         line_bad_in = fin_bad;
         if (kept) begin
            res.record_kept   = 1'b1;
            res.prefix_code   = pre_ext[PREFIX_CODE_W-1:0];
            res.suffix_code   = suffix_ff;
            res.kmer_count    = count_ff[COUNT_ACC_W-1] ? '1 : count_ff[KMER_COUNT_W-1:0];
            res.count_clamped = count_ff[COUNT_ACC_W-1];
            res.shard_index   = pre_shard[SHARD_W-1:0];
            if (kept_ff != '1) begin
               kept_in = kept_ff + 1'b1;
            end
         end
      end

      if (q_pop) begin
         rsp_valid_in = finish;
         rsp_data_in  = finish ? res : rsp_data_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_data_in  = rsp_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SKIP;
         kept_ff      <= '0;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         kept_ff      <= kept_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      prefix_ff    <= prefix_in;
      suffix_ff    <= suffix_in;
      count_ff     <= count_in;
      saw_digit_ff <= saw_digit_in;
      line_bad_ff  <= line_bad_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

// File: src/kmer_count_line_parser.sv
// Top level of the k-mer count line parser.
//
// req_*: one text byte per beat, or an end marker (end_of_input) that
//   finishes the line in progress. Lines read "<kmer> <count>".
// rsp_*: one beat per finished line: a kept record with packed prefix and
//   suffix codes, saturated count and shard index, or a skipped mark with all
//   other fields zero.
// csr_*: register 0 is the shard width, register 1 is the record limit;
//   csr_ready is always high. Write only while the parser is idle.
// Throughput is one byte per cycle while no result beat is held by rsp_stall:
// the front classifies each byte into a two-entry queue and the back does the
// whole per-byte state update, result included, as it pops the byte.
// The beat ending a line is written into the queue, popped by the back behind
// any entries waiting ahead, and its result is registered, raising rsp_valid.
// While rsp_stall holds a valid beat, the result register keeps it, the back stops
// draining, and req_stall rises once the queue has filled.
// Synchronous reset empties the queue and result register, returns the
// parser to skipping leading whitespace, clears the kept-record total and
// the stop flag, and loads a shard width of 12 and no record limit.
module kmer_count_line_parser
   import kclp_pkg::*;
#(
   parameter int PREFIX_BASES = 13,
   parameter int KMER_BASES   = 21
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [SHARD_WIDTH_W-1:0] shard_width_ff, shard_width_in;
   logic [MAX_REC_W-1:0]     max_records_ff, max_records_in;

   logic      queue_full, push, q_valid, q_pop;
   class_type push_item, q_item;

   assign csr_ready = 1'b1;

   always_comb begin
      shard_width_in = shard_width_ff;
      max_records_in = max_records_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SHARD_WIDTH: shard_width_in = csr_data[SHARD_WIDTH_W-1:0];
            CSR_MAX_RECORDS: max_records_in = csr_data[MAX_REC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shard_width_ff <= SHARD_WIDTH_RESET;
         max_records_ff <= MAX_RECORDS_RESET;
      end else begin
         shard_width_ff <= shard_width_in;
         max_records_ff <= max_records_in;
      end
   end

   kclp_front u_front (
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_stall  (req_stall),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   kclp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (q_item)
   );

   kclp_back #(
      .PREFIX_BASES (PREFIX_BASES),
      .KMER_BASES   (KMER_BASES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .shard_width (shard_width_ff),
      .max_records (max_records_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// File: src/kclp_checker.sv
// Port-level checks for the k-mer count line parser, bound to the top level.
module kclp_checker
   import kclp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // reset empties the result register
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a skipped line carries nothing but its mark
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.record_kept |->
         rsp_data.prefix_code == '0 && rsp_data.suffix_code == '0 &&
         rsp_data.kmer_count == '0 && !rsp_data.count_clamped &&
         rsp_data.shard_index == '0)
      else $error("skipped line with nonzero fields");

   // a clamped count is a kept record at full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.count_clamped |->
         rsp_data.record_kept && rsp_data.kmer_count == '1)
      else $error("clamp flag without saturated count");

endmodule

bind kmer_count_line_parser kclp_checker u_kclp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
